// ===== rtl/mmpd_pkg.sv =====
// Shared types, register map and constants for the min/max pixel decimator.
`timescale 1ns / 1ps
package mmpd_pkg;

  localparam int MAX_COLUMNS_DEF = 4096;
  // canvas_width is 13 bits, so no more columns than this can be addressed
  localparam int CANVAS_LIMIT    = 8191;
  localparam int PADDR_W         = 5;
  localparam int FIFO_DEPTH      = 8;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_X_OFFSET        = 3'd0;
  localparam reg_idx_t REG_PIXELS_PER_UNIT = 3'd1;
  localparam reg_idx_t REG_UNITS_PER_PIXEL = 3'd2;
  localparam reg_idx_t REG_CANVAS_WIDTH    = 3'd3;
  localparam reg_idx_t REG_DESCENDING      = 3'd4;
  localparam reg_idx_t REG_BYPASS          = 3'd5;

  localparam logic [31:0] X_OFFSET_RST        = 32'd0;
  localparam logic [31:0] PIXELS_PER_UNIT_RST = 32'd65536;
  localparam logic [31:0] UNITS_PER_PIXEL_RST = 32'd65536;
  localparam logic [12:0] CANVAS_WIDTH_RST    = 13'd1024;

  typedef struct packed {
    logic signed [31:0] x_offset;
    logic [31:0]        pixels_per_unit;
    logic [31:0]        units_per_pixel;
    logic [12:0]        canvas_width;
    logic               descending;
    logic               bypass;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } point_t;

  typedef struct packed {
    logic pre;     // sample lies before the displayed range
    logic tgt_ok;  // a column exists for the sample
  } map_flags_t;

  function automatic int col_bits(input int max_cols);
    int lim;
    lim = (max_cols < CANVAS_LIMIT) ? max_cols : CANVAS_LIMIT;
    return $clog2(lim + 1);
  endfunction

endpackage

// ===== rtl/mmpd_if.sv =====
// Valid/ready stream interfaces for samples in and points out.
`timescale 1ns / 1ps
interface mmpd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic               sample_last;

  modport source (output valid, output sample_x, output sample_y, output sample_last,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_last,
                output ready);
endinterface

interface mmpd_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               point_last;

  modport source (output valid, output point_x, output point_y, output point_last,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_last,
                output ready);
endinterface

// ===== rtl/mmpd_map.sv =====
// Pixel mapping pipeline: position, target column and column x for each sample.
`timescale 1ns / 1ps
module mmpd_map #(
  parameter int MAX_COLUMNS = mmpd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         adv,
  input  logic                                         in_valid,
  input  mmpd_pkg::point_t                             in_pt,
  input  mmpd_pkg::cfg_t                               cfg,
  output logic                                         out_valid,
  output mmpd_pkg::point_t                             out_pt,
  output logic signed [63:0]                           out_pos,
  output mmpd_pkg::map_flags_t                         out_flags,
  output logic [mmpd_pkg::col_bits(MAX_COLUMNS)-1:0]   out_tgt,
  output logic signed [31:0]                           out_cx
);
  import mmpd_pkg::*;

  localparam int COL_W = col_bits(MAX_COLUMNS);
  localparam logic [63:0]        POS_LIMIT = 64'h4000_0000_0000_0000;
  localparam logic signed [63:0] INT32_TOP = 64'sh7FFF_FFFF;

  logic       s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;
  point_t     s1_pt, s2_pt, s3_pt, s4_pt, s5_pt, s6_pt, s7_pt;
  logic [31:0] s2_mag;
  logic       s2_neg, s3_neg;
  logic [63:0] s3_prod;
  logic signed [63:0] s4_pos, s5_pos, s6_pos, s7_pos;
  map_flags_t s5_flags, s6_flags, s7_flags;
  logic [COL_W-1:0] s5_tgt, s6_tgt, s7_tgt;
  logic [COL_W+31:0] s6_cprod;
  logic signed [31:0] s7_cx;

  // effective canvas width
  logic [16:0]      cw_ext, weff_w;
  logic [COL_W-1:0] weff;
  always_comb begin
    cw_ext = {4'b0, cfg.canvas_width};
    weff_w = (cw_ext > 17'(MAX_COLUMNS)) ? 17'(MAX_COLUMNS) : cw_ext;
    weff   = weff_w[COL_W-1:0];
  end

  // stage 2: offset subtract and magnitude
  logic signed [32:0] d;
  logic [32:0]        d_neg;
  always_comb begin
    d     = $signed({s1_pt.x[31], s1_pt.x}) - $signed({cfg.x_offset[31], cfg.x_offset});
    d_neg = ~d + 33'd1;
  end

  // stage 4: saturation
  logic [63:0] prod_sat, prod_neg;
  always_comb begin
    prod_sat = (s3_prod > POS_LIMIT) ? POS_LIMIT : s3_prod;
    prod_neg = ~prod_sat + 64'd1;
  end

  // stage 5: before-range test and column search
  logic        pos_le0;
  logic [63:0] ceil_sum;
  logic [47:0] p_up, f_dn;
  logic        ok_a, ok_d;
  logic [COL_W-1:0] tgt_a, tgt_d;
  logic signed [63:0] wpos;
  logic        pre;
  always_comb begin
    pos_le0  = s4_pos[63] || (s4_pos == 64'sd0);
    ceil_sum = s4_pos + 64'sd65535;
    p_up     = ceil_sum[63:16] - 48'd1;
    ok_a     = pos_le0 ? (weff != '0) : (p_up < 48'(weff));
    tgt_a    = pos_le0 ? '0 : p_up[COL_W-1:0];
    f_dn     = s4_pos[63:16] + 48'd1;
    ok_d     = !s4_pos[63] && (weff != '0);
    tgt_d    = (f_dn > 48'(weff)) ? weff : f_dn[COL_W-1:0];
    wpos     = $signed(64'({weff, 16'b0}));
    pre      = cfg.descending ? (s4_pos >= wpos) : pos_le0;
  end

  // stage 7: column x rounding and saturation
  logic [COL_W+32:0]  cr_sum;
  logic [COL_W+16:0]  cr_t;
  logic signed [63:0] cx_wide;
  always_comb begin
    cr_sum  = {1'b0, s6_cprod} + (COL_W+33)'(32'h8000);
    cr_t    = cr_sum[COL_W+32:16];
    cx_wide = $signed({{32{cfg.x_offset[31]}}, cfg.x_offset}) + $signed(64'(cr_t));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt    <= in_pt;
      s2_pt    <= s1_pt;
      s2_neg   <= d[32];
      s2_mag   <= d[32] ? d_neg[31:0] : d[31:0];
      s3_pt    <= s2_pt;
      s3_neg   <= s2_neg;
      s3_prod  <= 64'(s2_mag) * 64'(cfg.pixels_per_unit);
      s4_pt    <= s3_pt;
      s4_pos   <= $signed(s3_neg ? prod_neg : prod_sat);
      s5_pt    <= s4_pt;
      s5_pos   <= s4_pos;
      s5_flags <= '{pre: pre, tgt_ok: cfg.descending ? ok_d : ok_a};
      s5_tgt   <= cfg.descending ? tgt_d : tgt_a;
      s6_pt    <= s5_pt;
      s6_pos   <= s5_pos;
      s6_flags <= s5_flags;
      s6_tgt   <= s5_tgt;
      s6_cprod <= (COL_W+32)'(s5_tgt) * (COL_W+32)'(cfg.units_per_pixel);
      s7_pt    <= s6_pt;
      s7_pos   <= s6_pos;
      s7_flags <= s6_flags;
      s7_tgt   <= s6_tgt;
      s7_cx    <= (cx_wide > INT32_TOP) ? 32'sh7FFF_FFFF : cx_wide[31:0];
    end
  end

  assign out_valid = s7_valid;
  assign out_pt    = s7_pt;
  assign out_pos   = s7_pos;
  assign out_flags = s7_flags;
  assign out_tgt   = s7_tgt;
  assign out_cx    = s7_cx;

endmodule

// ===== rtl/minmax_pixel_decimator_core.sv =====
// Top level: register port, curve state, min/max column reduction and output queue.
`timescale 1ns / 1ps
// Min/max pixel decimator. Samples (x, y) enter on the sample stream, one per
// cycle, and are reduced to at most two points per display column on the
// point stream. A sample passes the mapping stages in turn (input register,
// offset subtract, 32x32 position product, saturation, column search,
// column-x product, column-x rounding) to reach the curve state, and its
// points enter the eight-entry output queue on the edge that updates the
// curve state. The block takes one sample per cycle as long as the output
// queue has room for three points; each sample yields zero to three points,
// and points drain at one per cycle while the point stream is ready. Registers
// must be written through the APB port only while the block is idle, which the
// block does not enforce; a write takes effect for the samples that follow it.
module minmax_pixel_decimator_core #(
  parameter int MAX_COLUMNS = mmpd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  mmpd_sample_if.sink                   sample,
  mmpd_point_if.source                  point,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mmpd_pkg::*;

  localparam int COL_W   = col_bits(MAX_COLUMNS);
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_IN     = 2'd1;
  localparam logic [1:0] PH_AFTER  = 2'd2;

  // configuration registers
  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset        <= X_OFFSET_RST;
      cfg.pixels_per_unit <= PIXELS_PER_UNIT_RST;
      cfg.units_per_pixel <= UNITS_PER_PIXEL_RST;
      cfg.canvas_width    <= CANVAS_WIDTH_RST;
      cfg.descending      <= 1'b0;
      cfg.bypass          <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_X_OFFSET:        cfg.x_offset        <= pwdata;
        REG_PIXELS_PER_UNIT: cfg.pixels_per_unit <= pwdata;
        REG_UNITS_PER_PIXEL: cfg.units_per_pixel <= pwdata;
        REG_CANVAS_WIDTH:    cfg.canvas_width    <= pwdata[12:0];
        REG_DESCENDING:      cfg.descending      <= pwdata[0];
        REG_BYPASS:          cfg.bypass          <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_OFFSET:        prdata = cfg.x_offset;
      REG_PIXELS_PER_UNIT: prdata = cfg.pixels_per_unit;
      REG_UNITS_PER_PIXEL: prdata = cfg.units_per_pixel;
      REG_CANVAS_WIDTH:    prdata = {19'b0, cfg.canvas_width};
      REG_DESCENDING:      prdata = {31'b0, cfg.descending};
      REG_BYPASS:          prdata = {31'b0, cfg.bypass};
      default:             prdata = 32'd0;
    endcase
  end

  // output queue
  point_t           fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             adv, pop;

  assign adv = (count <= CNT_W'(FIFO_DEPTH - 3));
  assign pop = point.valid && point.ready;

  assign sample.ready     = adv;
  assign point.valid      = (count != '0);
  assign point.point_x    = fifo[rd_ptr].x;
  assign point.point_y    = fifo[rd_ptr].y;
  assign point.point_last = fifo[rd_ptr].last;

  // mapping pipeline
  point_t             in_pt, m_pt;
  logic               m_valid;
  logic signed [63:0] m_pos;
  map_flags_t         m_flags;
  logic [COL_W-1:0]   m_tgt;
  logic signed [31:0] m_cx;

  assign in_pt = '{x: sample.sample_x, y: sample.sample_y, last: sample.sample_last};

  mmpd_map #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .in_pt     (in_pt),
    .cfg       (cfg),
    .out_valid (m_valid),
    .out_pt    (m_pt),
    .out_pos   (m_pos),
    .out_flags (m_flags),
    .out_tgt   (m_tgt),
    .out_cx    (m_cx)
  );

  // curve state
  logic [1:0]         phase, phase_next;
  logic [COL_W-1:0]   col_idx, col_idx_next;
  logic [1:0]         col_cnt, col_cnt_next;
  logic signed [31:0] col_min, col_min_next;
  logic signed [31:0] col_max, col_max_next;
  logic signed [31:0] col_cx, col_cx_next;
  logic signed [31:0] single_x, single_x_next;
  logic signed [31:0] single_y, single_y_next;
  logic signed [31:0] held_x, held_x_next;
  logic signed [31:0] held_y, held_y_next;
  logic               held_valid, held_valid_next;

  point_t     em [3];
  logic [1:0] en;

  // column x of the open column, kept current across register writes
  logic [COL_W+31:0]  cx_prod;
  logic               cx_prod_ok;
  logic [COL_W+32:0]  cx_sum;
  logic [COL_W+16:0]  cx_t;
  logic signed [63:0] cx_full;
  logic signed [31:0] cx_cur;
  always_comb begin
    cx_sum  = {1'b0, cx_prod} + (COL_W+33)'(32'h8000);
    cx_t    = cx_sum[COL_W+32:16];
    cx_full = $signed({{32{cfg.x_offset[31]}}, cfg.x_offset}) + $signed(64'(cx_t));
    cx_cur  = (cx_full > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : cx_full[31:0];
  end

  // column boundaries around the open column
  logic [COL_W:0]            ci_up;
  logic signed [COL_W+1:0]   ci_dn;
  logic signed [63:0]        thr_up, thr_dn;
  logic                      fits;
  always_comb begin
    ci_up  = {1'b0, col_idx} + (COL_W+1)'(1);
    ci_dn  = $signed((COL_W+2)'(col_idx) - (COL_W+2)'(1));
    thr_up = $signed(64'({ci_up, 16'b0}));
    thr_dn = $signed({{(46-COL_W){ci_dn[COL_W+1]}}, ci_dn, 16'b0});
    fits   = cfg.descending ? (m_pos >= thr_dn) : (m_pos <= thr_up);
  end

  always_comb begin
    phase_next      = phase;
    col_idx_next    = col_idx;
    col_cnt_next    = col_cnt;
    col_min_next    = col_min;
    col_max_next    = col_max;
    col_cx_next     = cx_prod_ok ? cx_cur : col_cx;
    single_x_next   = single_x;
    single_y_next   = single_y;
    held_x_next     = held_x;
    held_y_next     = held_y;
    held_valid_next = held_valid;
    en              = '0;
    em              = '{default: '0};

    if (m_valid && adv) begin
      if (cfg.bypass) begin
        em[en] = m_pt;
        en     = en + 2'd1;
      end else begin
        unique case (phase)
          PH_BEFORE: begin
            if (m_flags.pre && !m_pt.last) begin
              held_x_next     = m_pt.x;
              held_y_next     = m_pt.y;
              held_valid_next = 1'b1;
            end else begin
              if (held_valid) begin
                em[en] = '{x: held_x, y: held_y, last: 1'b0};
                en     = en + 2'd1;
              end
              held_valid_next = 1'b0;
              if (m_pt.last || !m_flags.tgt_ok) begin
                em[en] = '{x: m_pt.x, y: m_pt.y, last: 1'b1};
                en     = en + 2'd1;
                phase_next = m_pt.last ? PH_BEFORE : PH_AFTER;
                col_idx_next = m_pt.last ? '0 : col_idx;
              end else begin
                phase_next    = PH_IN;
                col_idx_next  = m_tgt;
                col_cnt_next  = 2'd1;
                col_min_next  = m_pt.y;
                col_max_next  = m_pt.y;
                single_x_next = m_pt.x;
                single_y_next = m_pt.y;
                col_cx_next   = m_cx;
              end
            end
          end
          PH_IN: begin
            if (!m_pt.last && fits) begin
              if (col_cnt == 2'd0) begin
                col_cnt_next  = 2'd1;
                col_min_next  = m_pt.y;
                col_max_next  = m_pt.y;
                single_x_next = m_pt.x;
                single_y_next = m_pt.y;
              end else begin
                col_cnt_next = 2'd2;
                if (m_pt.y < col_min) col_min_next = m_pt.y;
                if (m_pt.y > col_max) col_max_next = m_pt.y;
              end
            end else begin
              // close the open column
              if (col_cnt == 2'd1) begin
                em[en] = '{x: single_x, y: single_y, last: 1'b0};
                en     = en + 2'd1;
              end else if (col_cnt != 2'd0) begin
                em[en] = '{x: col_cx, y: col_min, last: 1'b0};
                en     = en + 2'd1;
                em[en] = '{x: col_cx, y: col_max, last: 1'b0};
                en     = en + 2'd1;
              end
              if (m_pt.last || !m_flags.tgt_ok) begin
                em[en] = '{x: m_pt.x, y: m_pt.y, last: 1'b1};
                en     = en + 2'd1;
                col_cnt_next = 2'd0;
                phase_next   = m_pt.last ? PH_BEFORE : PH_AFTER;
                col_idx_next = m_pt.last ? '0 : col_idx;
              end else begin
                col_idx_next  = m_tgt;
                col_cnt_next  = 2'd1;
                col_min_next  = m_pt.y;
                col_max_next  = m_pt.y;
                single_x_next = m_pt.x;
                single_y_next = m_pt.y;
                col_cx_next   = m_cx;
              end
            end
          end
          PH_AFTER: begin
            if (m_pt.last) begin
              phase_next   = PH_BEFORE;
              col_idx_next = '0;
            end
          end
          default: begin
            phase_next   = PH_BEFORE;
            col_idx_next = '0;
            col_cnt_next = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_BEFORE;
      col_idx    <= '0;
      col_cnt    <= 2'd0;
      held_valid <= 1'b0;
      cx_prod_ok <= 1'b0;
    end else begin
      phase      <= phase_next;
      col_idx    <= col_idx_next;
      col_cnt    <= col_cnt_next;
      held_valid <= held_valid_next;
      cx_prod_ok <= !cfg_wr && (col_idx_next == col_idx);
    end
  end

  always_ff @(posedge clk) begin
    col_min  <= col_min_next;
    col_max  <= col_max_next;
    col_cx   <= col_cx_next;
    single_x <= single_x_next;
    single_y <= single_y_next;
    held_x   <= held_x_next;
    held_y   <= held_y_next;
    cx_prod  <= (COL_W+32)'(col_idx) * (COL_W+32)'(cfg.units_per_pixel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(en);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + CNT_W'(en) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < en) fifo[wr_ptr + PTR_W'(k)] <= em[k];
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_held_before: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (phase == PH_BEFORE))
    else $error("held sample outside before-range phase");

  a_column_open: assert property (@(posedge clk) disable iff (rst)
    (col_cnt != 2'd0) == (phase == PH_IN))
    else $error("open column does not match phase");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (en != 2'd0) |-> (count <= CNT_W'(FIFO_DEPTH - 3)))
    else $error("points pushed without queue room");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for minmax_pixel_decimator_core: random streams, APB setup, point checks.
`timescale 1ns / 1ps
module tb;
  import mmpd_pkg::*;

  localparam longint PIXEL = 65536;
  localparam logic [31:0] INT_LO = 32'h8000_0000;
  localparam logic [31:0] INT_HI = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {RANGE_PRE, RANGE_IN, RANGE_POST} range_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } sample_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  mmpd_sample_if smp_bus ();
  mmpd_point_if  pnt_bus ();

  minmax_pixel_decimator_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp_bus),
    .point   (pnt_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copy and curve state of the decimation predictor
  cfg_t    regs;
  range_e  crv_state;
  longint  col_idx;
  int      col_n;
  longint  col_lo;
  longint  col_hi;
  longint  only_x;
  longint  only_y;
  longint  hold_x;
  longint  hold_y;
  bit      hold_ok;

  sample_t queued_samples[$];
  point_t  due_points[$];
  sample_t cur_sample = '0;
  bit      sending = 1'b0;
  bit      s_calm = 1'b0;
  bit      r_calm = 1'b0;
  int      s_wait = 0;
  int      r_wait = 0;
  int      fail_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void add_point(longint x, longint y, bit last);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.last = last;
    due_points.push_back(p);
  endfunction

  function automatic void clear_curve();
    crv_state = RANGE_PRE;
    col_idx = 0;
    col_n = 0;
    col_lo = 0;
    col_hi = 0;
    only_x = 0;
    only_y = 0;
    hold_x = 0;
    hold_y = 0;
    hold_ok = 1'b0;
  endfunction

  function automatic longint eff_width();
    return (regs.canvas_width > MAX_COLUMNS_DEF) ? longint'(MAX_COLUMNS_DEF)
                                                 : longint'(regs.canvas_width);
  endfunction

  function automatic longint scaled_pos(longint sx);
    longint d;
    longint unsigned mag;
    longint unsigned prod;
    d = sx - longint'(regs.x_offset);
    mag = (d < 0) ? -d : d;
    prod = mag * 64'(regs.pixels_per_unit);
    if (prod > 64'h4000_0000_0000_0000) prod = 64'h4000_0000_0000_0000;
    return (d < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint column_x(longint p);
    longint unsigned t;
    longint r;
    t = (64'(p) * 64'(regs.units_per_pixel) + 64'h8000) >> 16;
    r = longint'(regs.x_offset) + longint'(t);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    return r;
  endfunction

  function automatic longint column_for(longint pos);
    longint w;
    longint p;
    w = eff_width();
    if (!regs.descending) begin
      if (pos <= 0) return (w > 0) ? 0 : -1;
      p = ((pos + PIXEL - 1) >>> 16) - 1;
      return (p < w) ? p : -1;
    end
    if (pos < 0) return -1;
    p = (pos >>> 16) + 1;
    if (p > w) p = w;
    return (p >= 1) ? p : -1;
  endfunction

  function automatic bit fits_column(longint pos);
    if (!regs.descending) return pos <= (col_idx + 1) * PIXEL;
    return pos >= (col_idx - 1) * PIXEL;
  endfunction

  function automatic void take_into_column(longint x, longint y);
    if (col_n == 0) begin
      col_lo = y;
      col_hi = y;
      only_x = x;
      only_y = y;
      col_n = 1;
    end else begin
      if (y < col_lo) col_lo = y;
      if (y > col_hi) col_hi = y;
      col_n = 2;
    end
  endfunction

  function automatic void flush_column();
    longint cx;
    if (col_n == 1) begin
      add_point(only_x, only_y, 1'b0);
    end else if (col_n >= 2) begin
      cx = column_x(col_idx);
      add_point(cx, col_lo, 1'b0);
      add_point(cx, col_hi, 1'b0);
    end
    col_n = 0;
  endfunction

  function automatic void decimate_sample(sample_t s);
    longint sx;
    longint sy;
    longint pos;
    longint tgt;
    bit     pre;
    sx = s.x;
    sy = s.y;
    if (regs.bypass) begin
      add_point(sx, sy, s.last);
      return;
    end
    pos = scaled_pos(sx);
    case (crv_state)
      RANGE_PRE: begin
        pre = regs.descending ? (pos >= eff_width() * PIXEL) : (pos <= 0);
        if (pre && !s.last) begin
          hold_x = sx;
          hold_y = sy;
          hold_ok = 1'b1;
          return;
        end
        if (hold_ok) add_point(hold_x, hold_y, 1'b0);
        if (s.last) begin
          add_point(sx, sy, 1'b1);
          clear_curve();
          return;
        end
        hold_ok = 1'b0;
        tgt = column_for(pos);
        if (tgt < 0) begin
          add_point(sx, sy, 1'b1);
          crv_state = RANGE_POST;
          return;
        end
        crv_state = RANGE_IN;
        col_idx = tgt;
        col_n = 0;
        take_into_column(sx, sy);
      end
      RANGE_IN: begin
        if (s.last) begin
          flush_column();
          add_point(sx, sy, 1'b1);
          clear_curve();
          return;
        end
        if (fits_column(pos)) begin
          take_into_column(sx, sy);
          return;
        end
        flush_column();
        tgt = column_for(pos);
        if (tgt < 0) begin
          add_point(sx, sy, 1'b1);
          crv_state = RANGE_POST;
          return;
        end
        col_idx = tgt;
        take_into_column(sx, sy);
      end
      default: begin
        if (s.last) clear_curve();
      end
    endcase
  endfunction

  function automatic void push_sample(logic [31:0] x, logic [31:0] y, bit last);
    sample_t s;
    s.x = x;
    s.y = y;
    s.last = last;
    queued_samples.push_back(s);
  endfunction

  // one curve sweeping from two pixels before the canvas to two pixels past it
  function automatic int queue_curve(int n);
    real    xu;
    real    lo;
    real    hi;
    real    stp;
    real    xr;
    longint xv;
    bit     drop_last;
    bit     last;
    logic [31:0] y;
    xu = (regs.pixels_per_unit == 0) ? 1.0 : 65536.0 / real'(regs.pixels_per_unit);
    lo = real'(longint'(regs.x_offset)) - 2.0 * xu;
    hi = real'(longint'(regs.x_offset)) + (real'(eff_width()) + 2.0) * xu;
    stp = (hi - lo) / real'(n - 1);
    drop_last = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) begin
      xr = regs.descending ? hi - i * stp : lo + i * stp;
      xr = xr + real'(int'($urandom_range(0, 600)) - 300) / 1000.0 * stp;
      if (xr > 2147483647.0) xr = 2147483647.0;
      if (xr < -2147483648.0) xr = -2147483648.0;
      xv = longint'(xr);
      if ($urandom_range(0, 11) == 0) xv = longint'($urandom);
      y = ($urandom_range(0, 3) == 0) ? $urandom : 32'(int'($urandom_range(0, 2000)) - 1000);
      last = ((i == n - 1) && !drop_last) || ($urandom_range(0, 59) == 0);
      push_sample(xv[31:0], y, last);
    end
    return n;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_X_OFFSET:        regs.x_offset = val;
      REG_PIXELS_PER_UNIT: regs.pixels_per_unit = val;
      REG_UNITS_PER_PIXEL: regs.units_per_pixel = val;
      REG_CANVAS_WIDTH:    regs.canvas_width = val[12:0];
      REG_DESCENDING:      regs.descending = val[0];
      REG_BYPASS:          regs.bypass = val[0];
      default: ;
    endcase
  endtask

  // samples that yield nothing may still sit in the 7-stage pipe
  task automatic wait_idle();
    while (queued_samples.size() != 0 || sending || due_points.size() != 0)
      @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] off, input logic [31:0] ppu,
                           input logic [31:0] upp, input logic [12:0] w, input bit desc,
                           input bit byp, input int n_items, input int noise_pct);
    int made;
    int left;
    wait_idle();
    write_reg(REG_X_OFFSET, off);
    write_reg(REG_PIXELS_PER_UNIT, ppu);
    write_reg(REG_UNITS_PER_PIXEL, upp);
    write_reg(REG_CANVAS_WIDTH, {19'd0, w});
    write_reg(REG_DESCENDING, {31'd0, desc});
    write_reg(REG_BYPASS, {31'd0, byp});
    made = 0;
    while (made < n_items) begin
      if (byp || $urandom_range(0, 99) < noise_pct) begin
        push_sample($urandom, $urandom, $urandom_range(0, 15) == 0);
        made++;
      end else begin
        left = n_items - made;
        made += queue_curve((left <= 4) ? 4
                            : int'($urandom_range(4, (left < 40) ? left : 40)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      smp_bus.valid <= 1'b0;
      sending = 1'b0;
    end else begin
      if (smp_bus.valid && smp_bus.ready) begin
        decimate_sample(cur_sample);
        sending = 1'b0;
        if ($urandom_range(0, 31) == 0) s_calm = !s_calm;
        s_wait = s_calm ? 0 : $urandom_range(0, 19);
      end
      if (!sending) begin
        if (s_wait > 0) begin
          s_wait--;
        end else if (queued_samples.size() > 0) begin
          cur_sample = queued_samples.pop_front();
          sending = 1'b1;
        end
      end
      smp_bus.valid <= sending;
      smp_bus.sample_x <= cur_sample.x;
      smp_bus.sample_y <= cur_sample.y;
      smp_bus.sample_last <= cur_sample.last;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      pnt_bus.ready <= 1'b0;
    end else begin
      if (pnt_bus.valid && pnt_bus.ready) begin
        if (due_points.size() == 0) begin
          $error("unexpected point x=%0d y=%0d last=%0b",
                 pnt_bus.point_x, pnt_bus.point_y, pnt_bus.point_last);
          fail_count++;
        end else begin
          want = due_points.pop_front();
          if (pnt_bus.point_x !== want.x) begin
            $error("point_x expected %0d got %0d", want.x, pnt_bus.point_x);
            fail_count++;
          end
          if (pnt_bus.point_y !== want.y) begin
            $error("point_y expected %0d got %0d", want.y, pnt_bus.point_y);
            fail_count++;
          end
          if (pnt_bus.point_last !== want.last) begin
            $error("point_last expected %0b got %0b", want.last, pnt_bus.point_last);
            fail_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) r_calm = !r_calm;
        r_wait = r_calm ? 0 : $urandom_range(0, 19);
      end
      if (r_wait > 0) begin
        r_wait--;
        pnt_bus.ready <= 1'b0;
      end else begin
        pnt_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("minmax_pixel_decimator_core verification failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    smp_bus.valid = 1'b0;
    smp_bus.sample_x = '0;
    smp_bus.sample_y = '0;
    smp_bus.sample_last = 1'b0;
    pnt_bus.ready = 1'b0;
    regs.x_offset = X_OFFSET_RST;
    regs.pixels_per_unit = PIXELS_PER_UNIT_RST;
    regs.units_per_pixel = UNITS_PER_PIXEL_RST;
    regs.canvas_width = CANVAS_WIDTH_RST;
    regs.descending = 1'b0;
    regs.bypass = 1'b0;
    clear_curve();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset setup: one pixel per unit, 1024 columns
    push_sample(-5, 7, 0);
    push_sample(-2, INT_LO, 0);
    push_sample(0, 5, 0);
    push_sample(1, 3, 0);
    push_sample(1, INT_HI, 0);
    push_sample(0, -9, 0);
    push_sample(2, -1, 0);
    push_sample(5, 4, 0);
    push_sample(1024, 6, 0);
    push_sample(1025, 8, 0);
    push_sample(3, 1, 0);
    push_sample(9, 2, 1);
    push_sample(INT_LO, -1, 0);
    push_sample(INT_HI, INT_LO, 1);
    push_sample(-1, 0, 0);
    push_sample(-7, 1, 1);
    push_sample(3, 10, 0);
    push_sample(3, 11, 0);
    push_sample(3, 12, 1);
    push_sample(1, 0, 1);

    run_phase(0, 32'd16384, 32'd262144, 13'd16, 1'b0, 1'b0, 40, 5);
    run_phase(-1000, 32'd196608, 32'd21845, 13'd8, 1'b1, 1'b0, 40, 5);
    run_phase($urandom, $urandom_range(1000, 1 << 20), $urandom, 13'd1, 1'b0, 1'b0, 25, 10);
    run_phase(0, 32'd65536, 32'd65536, 13'd0, 1'($urandom_range(0, 1)), 1'b0, 20, 20);
    run_phase(100, 32'd1048576, 32'd4096, 13'd8191, 1'b0, 1'b0, 30, 5);
    run_phase(0, 32'd65536, 32'd65536, 13'd16, 1'b0, 1'b1, 30, 100);
    run_phase(INT_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd4096, 1'b1, 1'b0, 30, 50);
    run_phase(32'sd2147482647, 32'd262144, 32'hFFFF_FFFF, 13'd64, 1'b0, 1'b0, 30, 5);
    run_phase(INT_HI, 32'd0, 32'd0, 13'd32, 1'($urandom_range(0, 1)), 1'b0, 15, 50);
    repeat (3) begin
      run_phase(32'(int'($urandom_range(0, 2000000)) - 1000000),
                $urandom_range(4096, 1 << 20), $urandom, 13'($urandom_range(1, 64)),
                1'($urandom_range(0, 1)), 1'b0, 25, 8);
    end
    run_phase(X_OFFSET_RST, PIXELS_PER_UNIT_RST, UNITS_PER_PIXEL_RST, CANVAS_WIDTH_RST,
              1'b0, 1'b0, 15, 10);

    wait_idle();
    repeat (24) @(posedge clk);
    if (fail_count == 0 && due_points.size() == 0) begin
      $display("minmax_pixel_decimator_core verification clean");
    end else begin
      $display("minmax_pixel_decimator_core verification failed");
    end
    $finish;
  end

endmodule
